>>> sv/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the turtle line interpreter
// Symbol codes, configuration register indexes, result kinds, internal
// operation codes and the fixed-point coefficients of the quarter sine.
// ----------------------------------------------------------------------------
package tli_pkg;

    // Symbols with a fixed meaning.
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_OPEN  = 8'h28;
    localparam logic [7:0] SYM_CLOSE = 8'h29;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MASK_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MASK_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MASK_2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MASK_3   = 3'd5;
    localparam int unsigned CFG_DATA_W = 64;

    // Result kinds.
    localparam logic [1:0] KIND_NEW       = 2'd0;
    localparam logic [1:0] KIND_EXTEND    = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
    localparam logic [1:0] KIND_UNDERFLOW = 2'd3;

    // Operation decided for an item when it is accepted.
    typedef enum logic [2:0] {
        OP_TURN,
        OP_PUSH,
        OP_POP,
        OP_OVF,
        OP_UNF,
        OP_MOVE,
        OP_RESTART
    } t_op;

    // Quarter sine: sin(pi/2 * x / 2^30) as a Q30 odd polynomial.
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [30:0] CO_A1   = 31'd1686629713;
    localparam logic [29:0] CO_B3   = 30'd693598668;
    localparam logic [26:0] CO_B5   = 27'd85569306;
    localparam logic [22:0] CO_B7   = 23'd5026995;
    localparam logic [17:0] CO_B9   = 18'd172272;
    localparam int unsigned QS_LAT  = 6;

    // Control of a pose stack.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_status;

    // One result beat.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] xe;
        logic signed [31:0] ye;
    } t_seg;

endpackage

>>> sv/tli_in_if.sv
// ----------------------------------------------------------------------------
// tli_in_if: symbol input channel
// Valid/ready channel carrying one action bit and one symbol byte per beat.
// ----------------------------------------------------------------------------
interface tli_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

>>> sv/tli_out_if.sv
// ----------------------------------------------------------------------------
// tli_out_if: segment output channel
// Valid/ready channel carrying one segment or stack error per beat.
// ----------------------------------------------------------------------------
interface tli_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] x_start;
    logic signed [31:0] y_start;
    logic signed [31:0] x_end;
    logic signed [31:0] y_end;

    modport source (output valid, output kind, output x_start, output y_start,
                    output x_end, output y_end, input ready);
    modport sink   (input valid, input kind, input x_start, input y_start,
                    input x_end, input y_end, output ready);
endinterface

>>> sv/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/tli_stack.sv
// ----------------------------------------------------------------------------
// tli_stack: bounded LIFO with a cached top entry
// The top entry lives in a register; deeper entries live in a RAM whose
// registered read always fetches the entry just below the next top, so a pop
// can complete in every cycle.
// ----------------------------------------------------------------------------
module tli_stack #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tli_pkg::t_stk_cmd    i_cmd,
    input  logic [WIDTH-1:0]     i_wdata,
    output logic [WIDTH-1:0]     o_top,
    output tli_pkg::t_stk_status o_status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = $clog2(DEPTH + 1);

    logic [LW-1:0]    r_level, n_level;
    logic [WIDTH-1:0] r_top, n_top;
    logic             r_fwd_v;
    logic [WIDTH-1:0] r_fwd_data;
    logic [WIDTH-1:0] ram_rdata;
    logic [WIDTH-1:0] below;
    logic             we;
    logic [LW:0]      waddr_full;
    logic [LW:0]      raddr_full;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    // The entry below the top: the RAM read, or the value written into that
    // very slot during the previous cycle.
    assign below = r_fwd_v ? r_fwd_data : ram_rdata;

    always_comb begin
        n_level = r_level;
        n_top   = r_top;
        we      = 1'b0;
        if (i_cmd.clear) begin
            n_level = '0;
        end else if (i_cmd.push) begin
            we      = (r_level != '0);
            n_top   = i_wdata;
            n_level = r_level + LW'(1);
        end else if (i_cmd.pop) begin
            n_top   = below;
            n_level = r_level - LW'(1);
        end
    end

    assign waddr_full = {1'b0, r_level} - (LW + 1)'(1);
    assign raddr_full = {1'b0, n_level} - (LW + 1)'(2);
    assign waddr      = waddr_full[AW-1:0];
    assign raddr      = raddr_full[AW-1:0];

    tli_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_top),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            r_level <= n_level;
            r_fwd_v <= we && (waddr == raddr);
        end
        r_top      <= n_top;
        r_fwd_data <= r_top;
    end

    assign o_top          = r_top;
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == LW'(DEPTH));

`ifndef SYNTH
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_level != '0)
        else $error("pop issued on an empty stack");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_level != LW'(DEPTH))
        else $error("push issued on a full stack");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.push, i_cmd.pop, i_cmd.clear}))
        else $error("more than one stack command in a cycle");
`endif

endmodule

>>> sv/tli_qsine.sv
// ----------------------------------------------------------------------------
// tli_qsine: pipelined quarter-wave sine
// Evaluates the Q30 odd polynomial by Horner steps, one multiply per stage,
// and rounds the result to Q16 capped at one.
// ----------------------------------------------------------------------------
module tli_qsine (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [16:0] o_sin
);

    logic [30:0] r_x_s1, r_x_s2, r_x_s3, r_x_s4, r_x_s5;
    logic [30:0] r_sq_s1, r_sq_s2, r_sq_s3, r_sq_s4;
    logic [22:0] r_p7;
    logic [26:0] r_p5;
    logic [29:0] r_p3;
    logic [30:0] r_p1;

    logic [61:0] m_sq;
    logic [48:0] m_7;
    logic [53:0] m_5;
    logic [57:0] m_3;
    logic [60:0] m_1;
    logic [61:0] m_0;
    logic [31:0] s_q30;
    logic [32:0] s_rnd;
    logic [18:0] s_q16;
    logic [16:0] s_cap;

    assign m_sq = 62'(i_x) * 62'(i_x);
    assign m_7  = 49'(r_sq_s1) * 49'(tli_pkg::CO_B9);
    assign m_5  = 54'(r_sq_s2) * 54'(r_p7);
    assign m_3  = 58'(r_sq_s3) * 58'(r_p5);
    assign m_1  = 61'(r_sq_s4) * 61'(r_p3);
    assign m_0  = 62'(r_x_s5) * 62'(r_p1);

    // Round half up from Q30 to Q16 and cap at 1.0.
    assign s_q30 = 32'(m_0 >> 30);
    assign s_rnd = 33'(s_q30) + 33'(8192);
    assign s_q16 = 19'(s_rnd >> 14);
    assign s_cap = (s_q16 > 19'h10000) ? 17'h10000 : s_q16[16:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_s1  <= i_x;
            r_sq_s1 <= 31'(m_sq >> 30);
            r_x_s2  <= r_x_s1;
            r_sq_s2 <= r_sq_s1;
            r_p7    <= tli_pkg::CO_B7 - 23'(m_7 >> 30);
            r_x_s3  <= r_x_s2;
            r_sq_s3 <= r_sq_s2;
            r_p5    <= tli_pkg::CO_B5 - 27'(m_5 >> 30);
            r_x_s4  <= r_x_s3;
            r_sq_s4 <= r_sq_s3;
            r_p3    <= tli_pkg::CO_B3 - 30'(m_3 >> 30);
            r_x_s5  <= r_x_s4;
            r_p1    <= tli_pkg::CO_A1 - 31'(m_1 >> 30);
            o_sin   <= s_cap;
        end
    end

endmodule

>>> sv/turtle_line_interpreter.sv
// ----------------------------------------------------------------------------
// turtle_line_interpreter: 2D turtle over a stream of L-system symbols
// Turns, saves and restores poses, steps one unit along the heading and
// emits new or extended line segments and stack errors.
// ----------------------------------------------------------------------------
// Throughput: one symbol beat per cycle through the six-stage sine pipeline
// and the position update in the last stage.
// The input stalls only while a result waits in the skid register.
// Reset is synchronous and active low; it clears the pose, the stack levels,
// the configuration registers and all valid flags. No clearing pass is run.
// ----------------------------------------------------------------------------
module turtle_line_interpreter #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned ANGLE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tli_in_if.sink                              i_sym,
    tli_out_if.source                           o_seg,
    input  logic                                i_cfg_we,
    input  logic [tli_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tli_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned SCALE_SH = 40 - ANGLE_BITS;
    localparam int unsigned LAT      = tli_pkg::QS_LAT;

    // Per-item information that travels alongside the sine pipeline.
    typedef struct packed {
        logic         valid;
        tli_pkg::t_op op;
        logic [7:0]   sym;
        logic         draw;
        logic [1:0]   quad;
    } t_side;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [15:0]  r_start_heading;
    logic [15:0]  r_turn_step;
    logic [255:0] r_draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_heading <= '0;
            r_turn_step     <= '0;
            r_draw          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tli_pkg::CFG_START_HEADING: r_start_heading <= i_cfg_data[15:0];
                tli_pkg::CFG_TURN_STEP:     r_turn_step     <= i_cfg_data[15:0];
                tli_pkg::CFG_DRAW_MASK_0:   r_draw[0 +: 64]   <= i_cfg_data;
                tli_pkg::CFG_DRAW_MASK_1:   r_draw[64 +: 64]  <= i_cfg_data;
                tli_pkg::CFG_DRAW_MASK_2:   r_draw[128 +: 64] <= i_cfg_data;
                tli_pkg::CFG_DRAW_MASK_3:   r_draw[192 +: 64] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The 16-bit register turn fractions are scaled to the heading width by
    // a constant shift: left when the heading is wider, right when narrower.
    logic [ANGLE_BITS-1:0] start_sc;
    logic [ANGLE_BITS-1:0] turn_sc;

    assign start_sc = ANGLE_BITS'({r_start_heading, 24'b0} >> SCALE_SH);
    assign turn_sc  = ANGLE_BITS'({r_turn_step, 24'b0} >> SCALE_SH);

    // ------------------------------------------------------------------
    // Pipeline enable and handshake. Everything advances together unless a
    // result is parked in the skid register.
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic en;
    logic acc;

    assign en          = !r_skid_v;
    assign i_sym.ready = en;
    assign acc         = i_sym.valid && en;

    // ------------------------------------------------------------------
    // Front stage: heading tracking and the heading stack. The heading is
    // needed here so that the sine lookup can start on the accepted beat;
    // the stack level seen here decides overflow and underflow.
    // ------------------------------------------------------------------
    logic [ANGLE_BITS-1:0] r_heading, n_heading;
    tli_pkg::t_op          f_op;
    tli_pkg::t_stk_cmd     hcmd;
    tli_pkg::t_stk_status  hstat;
    logic [ANGLE_BITS-1:0] htop;

    always_comb begin
        f_op      = tli_pkg::OP_TURN;
        n_heading = r_heading;
        hcmd      = '0;
        if (i_sym.action) begin
            f_op       = tli_pkg::OP_RESTART;
            n_heading  = start_sc;
            hcmd.clear = 1'b1;
        end else begin
            unique case (i_sym.symbol)
                tli_pkg::SYM_PLUS: begin
                    n_heading = r_heading + turn_sc;
                end
                tli_pkg::SYM_MINUS: begin
                    n_heading = r_heading - turn_sc;
                end
                tli_pkg::SYM_OPEN: begin
                    if (hstat.full) begin
                        f_op = tli_pkg::OP_OVF;
                    end else begin
                        f_op      = tli_pkg::OP_PUSH;
                        hcmd.push = 1'b1;
                    end
                end
                tli_pkg::SYM_CLOSE: begin
                    if (hstat.empty) begin
                        f_op = tli_pkg::OP_UNF;
                    end else begin
                        f_op      = tli_pkg::OP_POP;
                        hcmd.pop  = 1'b1;
                        n_heading = htop;
                    end
                end
                default: begin
                    f_op = tli_pkg::OP_MOVE;
                end
            endcase
        end
        if (!acc) begin
            hcmd      = '0;
            n_heading = r_heading;
        end
    end

    tli_stack #(
        .WIDTH (ANGLE_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_head_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (hcmd),
        .i_wdata  (r_heading),
        .o_top    (htop),
        .o_status (hstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else begin
            r_heading <= n_heading;
        end
    end

    // The heading as a 32-bit turn fraction: two quadrant bits and a 30-bit
    // position within the quadrant. The step uses sin of that position and
    // sin of its complement, which is the cosine.
    logic [31:0] turn32;
    logic [30:0] x_f;
    logic [30:0] x_g;
    logic [16:0] sin_f;
    logic [16:0] sin_g;

    assign turn32 = {r_heading, {(32 - ANGLE_BITS){1'b0}}};
    assign x_f    = {1'b0, turn32[29:0]};
    assign x_g    = tli_pkg::ONE_Q30 - x_f;

    tli_qsine u_sin_f (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (x_f),
        .o_sin (sin_f)
    );

    tli_qsine u_sin_g (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (x_g),
        .o_sin (sin_g)
    );

    // Side information delayed to line up with the sine results.
    t_side r_side [LAT];
    t_side f_side;

    always_comb begin
        f_side.valid = acc;
        f_side.op    = f_op;
        f_side.sym   = i_sym.symbol;
        f_side.draw  = r_draw[i_sym.symbol];
        f_side.quad  = turn32[31:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_side[0] <= f_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Last stage: position update, the position stack and the segment
    // bookkeeping. An item here is processed in the cycle it leaves.
    // ------------------------------------------------------------------
    t_side       e;
    logic        e_go;
    logic [31:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [31:0] r_seg_x, r_seg_y, n_seg_x, n_seg_y;
    logic [7:0]  r_prev_sym, n_prev_sym;
    logic        r_prev_v, n_prev_v;
    logic [31:0] mv_x, mv_y;
    logic        res_v;
    tli_pkg::t_seg res;
    tli_pkg::t_stk_cmd pcmd;
    logic [63:0] ptop;

    assign e    = r_side[LAT-1];
    assign e_go = en && e.valid;

    // One unit step along the heading, built from the quarter sine by
    // quadrant symmetry. Positions wrap modulo 2^32.
    always_comb begin
        case (e.quad)
            2'd0: begin
                mv_x = r_pos_x + 32'(sin_g);
                mv_y = r_pos_y + 32'(sin_f);
            end
            2'd1: begin
                mv_x = r_pos_x - 32'(sin_f);
                mv_y = r_pos_y + 32'(sin_g);
            end
            2'd2: begin
                mv_x = r_pos_x - 32'(sin_g);
                mv_y = r_pos_y - 32'(sin_f);
            end
            default: begin
                mv_x = r_pos_x + 32'(sin_f);
                mv_y = r_pos_y - 32'(sin_g);
            end
        endcase
    end

    always_comb begin
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_seg_x    = r_seg_x;
        n_seg_y    = r_seg_y;
        n_prev_sym = e.sym;
        n_prev_v   = r_prev_v;
        pcmd       = '0;
        res_v      = 1'b0;
        res.kind   = tli_pkg::KIND_OVERFLOW;
        res.xs     = r_pos_x;
        res.ys     = r_pos_y;
        res.xe     = r_pos_x;
        res.ye     = r_pos_y;
        unique case (e.op)
            tli_pkg::OP_RESTART: begin
                n_pos_x    = '0;
                n_pos_y    = '0;
                n_seg_x    = '0;
                n_seg_y    = '0;
                n_prev_sym = '0;
                n_prev_v   = 1'b0;
                pcmd.clear = 1'b1;
            end
            tli_pkg::OP_TURN: begin
            end
            tli_pkg::OP_PUSH: begin
                pcmd.push = 1'b1;
            end
            tli_pkg::OP_POP: begin
                pcmd.pop = 1'b1;
                n_pos_x  = ptop[63:32];
                n_pos_y  = ptop[31:0];
            end
            tli_pkg::OP_OVF: begin
                res_v    = 1'b1;
                res.kind = tli_pkg::KIND_OVERFLOW;
            end
            tli_pkg::OP_UNF: begin
                res_v    = 1'b1;
                res.kind = tli_pkg::KIND_UNDERFLOW;
            end
            tli_pkg::OP_MOVE: begin
                n_pos_x = mv_x;
                n_pos_y = mv_y;
                res.xe  = mv_x;
                res.ye  = mv_y;
                if (e.draw) begin
                    res_v = 1'b1;
                    if (r_prev_v && (r_prev_sym == e.sym)) begin
                        // Same drawn symbol again: the last segment grows.
                        res.kind = tli_pkg::KIND_EXTEND;
                        res.xs   = r_seg_x;
                        res.ys   = r_seg_y;
                    end else begin
                        res.kind = tli_pkg::KIND_NEW;
                        n_seg_x  = r_pos_x;
                        n_seg_y  = r_pos_y;
                        n_prev_v = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!e_go) begin
            pcmd = '0;
        end
    end

    tli_stack #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_pos_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (pcmd),
        .i_wdata  ({r_pos_x, r_pos_y}),
        .o_top    (ptop),
        .o_status ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_seg_x    <= '0;
            r_seg_y    <= '0;
            r_prev_sym <= '0;
            r_prev_v   <= 1'b0;
        end else if (e_go) begin
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_seg_x    <= n_seg_x;
            r_seg_y    <= n_seg_y;
            r_prev_sym <= n_prev_sym;
            r_prev_v   <= n_prev_v;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a one-entry skid. A new result goes straight to
    // the output register when it is free or being drained, otherwise into
    // the skid, which then holds the pipeline until the output drains.
    // ------------------------------------------------------------------
    tli_pkg::t_seg r_out;
    tli_pkg::t_seg r_skid;
    logic          r_out_v;
    logic          take;
    logic          new_v;

    assign take  = r_out_v && o_seg.ready;
    assign new_v = e_go && res_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || take) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else if (new_v) begin
                r_out   <= res;
                r_out_v <= 1'b1;
            end else begin
                r_out_v <= 1'b0;
            end
        end else if (new_v) begin
            r_skid   <= res;
            r_skid_v <= 1'b1;
        end
    end

    assign o_seg.valid   = r_out_v;
    assign o_seg.kind    = r_out.kind;
    assign o_seg.x_start = r_out.xs;
    assign o_seg.y_start = r_out.ys;
    assign o_seg.x_end   = r_out.xe;
    assign o_seg.y_end   = r_out.ye;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a beat while the output is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_seg.ready))
        else $error("skid register filled without an output stall");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the turtle line interpreter
// Streams symbol beats with bursty timing into the block, follows the turtle
// pose, stack and segment history beat by beat, and compares every segment
// and stack error that comes out against the pose it should carry.
// ----------------------------------------------------------------------------
module testbench;

    // The block is built with the defaults that the tracker below assumes.
    localparam int unsigned POSE_STACK_DEPTH = 32;
    localparam int unsigned HEADING_BITS     = 16;

    // Cycles a symbol needs to leave the pipeline, with some margin. Used
    // before a register write and before the final verdict.
    localparam int unsigned SETTLE_CYCLES = 12;

    // The watchdog ends the run after this many cycles without any beat.
    localparam int unsigned QUIET_LIMIT = 3000;

    // Length of the single long stall on the segment side.
    localparam int unsigned SQUEEZE_CYCLES = 200;

    // Random beats per configuration phase, and the number of phases.
    localparam int unsigned PHASE_BEATS = 180;
    localparam int unsigned PHASE_COUNT = 6;

    // Quarter sine coefficients in Q30: sin(pi/2 * x) as an odd polynomial.
    localparam longint unsigned SINE_A1 = 64'd1686629713;
    localparam longint unsigned SINE_B3 = 64'd693598668;
    localparam longint unsigned SINE_B5 = 64'd85569306;
    localparam longint unsigned SINE_B7 = 64'd5026995;
    localparam longint unsigned SINE_B9 = 64'd172272;
    localparam logic [30:0]     QUARTER_TURN = 31'h4000_0000;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One symbol beat as planned by the stimulus.
    typedef struct {
        bit         action;
        logic [7:0] symbol;
    } t_turtle_cmd;

    // ------------------------------------------------------------------------
    // Turtle tracker: follows pose, heading, pose stack and segment history,
    // and holds the segments that the block still owes.
    // ------------------------------------------------------------------------
    class t_turtle_tracker;
        logic [15:0] start_heading;
        logic [15:0] turn_step;
        logic [63:0] draw_mask [4];

        logic [31:0] pos_x, pos_y;
        logic [HEADING_BITS-1:0] heading;
        logic [31:0] saved_x [POSE_STACK_DEPTH];
        logic [31:0] saved_y [POSE_STACK_DEPTH];
        logic [HEADING_BITS-1:0] saved_heading [POSE_STACK_DEPTH];
        int unsigned depth;
        logic [7:0]  last_symbol;
        bit          segment_open;
        logic [31:0] seg_start_x, seg_start_y;

        tli_pkg::t_seg due_segments [$];
        int unsigned   faults;

        function new();
            start_heading = '0;
            turn_step     = '0;
            foreach (draw_mask[i]) draw_mask[i] = '0;
            restart();
            faults = 0;
        endfunction

        function void restart();
            pos_x        = '0;
            pos_y        = '0;
            heading      = start_heading;
            depth        = 0;
            last_symbol  = '0;
            segment_open = 1'b0;
            seg_start_x  = '0;
            seg_start_y  = '0;
        endfunction

        function void write_register(logic [tli_pkg::CFG_IDX_W-1:0] idx,
                                     logic [tli_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tli_pkg::CFG_START_HEADING: start_heading = data[15:0];
                tli_pkg::CFG_TURN_STEP:     turn_step     = data[15:0];
                tli_pkg::CFG_DRAW_MASK_0:   draw_mask[0]  = data;
                tli_pkg::CFG_DRAW_MASK_1:   draw_mask[1]  = data;
                tli_pkg::CFG_DRAW_MASK_2:   draw_mask[2]  = data;
                tli_pkg::CFG_DRAW_MASK_3:   draw_mask[3]  = data;
                default: ;
            endcase
        endfunction

        // sin(pi/2 * x / 2^30) rounded to Q16 and capped at 1.0.
        function logic [16:0] quarter_sine(logic [30:0] x);
            longint unsigned xx, x2, p, s;
            xx = 64'(x);
            x2 = (xx * xx) >> 30;
            p  = SINE_B7 - ((x2 * SINE_B9) >> 30);
            p  = SINE_B5 - ((x2 * p) >> 30);
            p  = SINE_B3 - ((x2 * p) >> 30);
            p  = SINE_A1 - ((x2 * p) >> 30);
            s  = (xx * p) >> 30;
            s  = (s + 64'd8192) >> 14;
            if (s > 64'd65536) begin
                s = 64'd65536;
            end
            return s[16:0];
        endfunction

        // One unit step along the heading; the quadrant picks signs and
        // swaps the sine and cosine parts.
        function void advance();
            logic [31:0] turn;
            logic [30:0] frac;
            logic [31:0] across, along;
            turn   = {heading, 16'h0000};
            frac   = {1'b0, turn[29:0]};
            across = 32'(quarter_sine(frac));
            along  = 32'(quarter_sine(QUARTER_TURN - frac));
            case (turn[31:30])
                2'd0: begin
                    pos_x = pos_x + along;
                    pos_y = pos_y + across;
                end
                2'd1: begin
                    pos_x = pos_x - across;
                    pos_y = pos_y + along;
                end
                2'd2: begin
                    pos_x = pos_x - along;
                    pos_y = pos_y - across;
                end
                default: begin
                    pos_x = pos_x + across;
                    pos_y = pos_y - along;
                end
            endcase
        endfunction

        function void owe_segment(logic [1:0] kind, logic [31:0] xs, logic [31:0] ys,
                                  logic [31:0] xe, logic [31:0] ye);
            tli_pkg::t_seg seg;
            seg.kind = kind;
            seg.xs   = xs;
            seg.ys   = ys;
            seg.xe   = xe;
            seg.ye   = ye;
            due_segments.insert(due_segments.size(), seg);
        endfunction

        // Called for every accepted symbol beat, in acceptance order.
        function void take_symbol(bit action, logic [7:0] sym);
            logic [31:0] from_x, from_y;
            bit          draws;
            if (action) begin
                restart();
                return;
            end
            case (sym)
                tli_pkg::SYM_PLUS:  heading = heading + turn_step;
                tli_pkg::SYM_MINUS: heading = heading - turn_step;
                tli_pkg::SYM_OPEN: begin
                    if (depth >= POSE_STACK_DEPTH) begin
                        owe_segment(tli_pkg::KIND_OVERFLOW, pos_x, pos_y, pos_x, pos_y);
                    end else begin
                        saved_x[depth]       = pos_x;
                        saved_y[depth]       = pos_y;
                        saved_heading[depth] = heading;
                        depth++;
                    end
                end
                tli_pkg::SYM_CLOSE: begin
                    if (depth == 0) begin
                        owe_segment(tli_pkg::KIND_UNDERFLOW, pos_x, pos_y, pos_x, pos_y);
                    end else begin
                        depth--;
                        pos_x   = saved_x[depth];
                        pos_y   = saved_y[depth];
                        heading = saved_heading[depth];
                    end
                end
                default: begin
                    draws  = draw_mask[sym[7:6]][sym[5:0]];
                    from_x = pos_x;
                    from_y = pos_y;
                    advance();
                    if (draws) begin
                        // A repeat of the drawing symbol stretches the open
                        // segment instead of starting a new one.
                        if (segment_open && last_symbol == sym) begin
                            owe_segment(tli_pkg::KIND_EXTEND, seg_start_x, seg_start_y,
                                        pos_x, pos_y);
                        end else begin
                            seg_start_x  = from_x;
                            seg_start_y  = from_y;
                            segment_open = 1'b1;
                            owe_segment(tli_pkg::KIND_NEW, from_x, from_y, pos_x, pos_y);
                        end
                    end
                end
            endcase
            last_symbol = sym;
        endfunction

        // Called for every accepted result beat.
        function void match_segment(tli_pkg::t_seg got);
            tli_pkg::t_seg want;
            if (due_segments.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("unexpected beat: kind %0d (%h,%h)->(%h,%h)",
                             got.kind, got.xs, got.ys, got.xe, got.ye);
                end
                return;
            end
            want = due_segments.pop_front();
            if (got.kind !== want.kind || got.xs !== want.xs || got.ys !== want.ys ||
                got.xe !== want.xe || got.ye !== want.ye) begin
                faults++;
                if (faults <= 10) begin
                    $display("segment mismatch: expected kind %0d (%h,%h)->(%h,%h)",
                             want.kind, want.xs, want.ys, want.xe, want.ye);
                    $display("                  got      kind %0d (%h,%h)->(%h,%h)",
                             got.kind, got.xs, got.ys, got.xe, got.ye);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [tli_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [tli_pkg::CFG_DATA_W-1:0] cfg_data;

    tli_in_if  sym_if ();
    tli_out_if seg_if ();

    turtle_line_interpreter #(
        .STACK_DEPTH (POSE_STACK_DEPTH),
        .ANGLE_BITS  (HEADING_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sym      (sym_if),
        .o_seg      (seg_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_turtle_tracker tracker = new();

    // Beats waiting to be offered to the block.
    t_turtle_cmd beat_plan [$];

    // Raised by the stimulus when the long segment-side stall should start.
    bit squeeze_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    function void plan_beat(bit action, logic [7:0] sym);
        t_turtle_cmd beat;
        beat.action = action;
        beat.symbol = sym;
        beat_plan.insert(beat_plan.size(), beat);
    endfunction

    // A moving symbol: mostly one of a few fixed codes so that runs and repeats
    // across fragments line up, otherwise any byte but the four specials.
    function logic [7:0] pick_mover();
        logic [7:0] sym;
        case ($urandom_range(0, 5))
            0: sym = "F";
            1: sym = "G";
            2: sym = 8'h00;
            3: sym = 8'hFF;
            default: sym = 8'($urandom);
        endcase
        if (sym == tli_pkg::SYM_PLUS || sym == tli_pkg::SYM_MINUS ||
            sym == tli_pkg::SYM_OPEN || sym == tli_pkg::SYM_CLOSE) begin
            sym = "F";
        end
        return sym;
    endfunction

    // Appends one fragment of symbols. Most fragments look like the output of
    // a rewriting engine: runs of drawing symbols, turns and balanced branches.
    // The rest are deep push/pop runs that cross the stack depth, restarts and
    // plain noise.
    function void compose_fragment();
        int unsigned pick, len, nest, pushes, pops, k;
        logic [7:0]  sym;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            len  = $urandom_range(3, 14);
            nest = 0;
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        sym = pick_mover();
                        repeat ($urandom_range(1, 4)) plan_beat(1'b0, sym);
                    end
                    4: plan_beat(1'b0, tli_pkg::SYM_PLUS);
                    5: plan_beat(1'b0, tli_pkg::SYM_MINUS);
                    6, 7: begin
                        if (nest < 8) begin
                            plan_beat(1'b0, tli_pkg::SYM_OPEN);
                            nest++;
                        end
                    end
                    8: begin
                        if (nest > 0) begin
                            plan_beat(1'b0, tli_pkg::SYM_CLOSE);
                            nest--;
                        end
                    end
                    default: plan_beat(1'b0, 8'($urandom));
                endcase
            end
            repeat (nest) plan_beat(1'b0, tli_pkg::SYM_CLOSE);
        end else if (pick < 72) begin
            pushes = $urandom_range(28, 36);
            pops   = $urandom_range(pushes - 1, pushes + 2);
            repeat (pushes) plan_beat(1'b0, tli_pkg::SYM_OPEN);
            plan_beat(1'b0, pick_mover());
            repeat (pops) plan_beat(1'b0, tli_pkg::SYM_CLOSE);
        end else if (pick < 80) begin
            plan_beat(1'b1, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                plan_beat(($urandom_range(0, 15) == 0), 8'($urandom));
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Holds the write enable high for one edge; the caller lowers it after
    // the last write so that it is never lowered and raised in one step.
    task automatic write_reg(logic [tli_pkg::CFG_IDX_W-1:0] idx,
                             logic [tli_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        tracker.write_register(idx, data);
    endtask

    task automatic program_registers(logic [15:0] start, logic [15:0] turn,
                                     logic [63:0] m0, logic [63:0] m1,
                                     logic [63:0] m2, logic [63:0] m3);
        write_reg(tli_pkg::CFG_START_HEADING, 64'(start));
        write_reg(tli_pkg::CFG_TURN_STEP, 64'(turn));
        write_reg(tli_pkg::CFG_DRAW_MASK_0, m0);
        write_reg(tli_pkg::CFG_DRAW_MASK_1, m1);
        write_reg(tli_pkg::CFG_DRAW_MASK_2, m2);
        write_reg(tli_pkg::CFG_DRAW_MASK_3, m3);
        cfg_we <= 1'b0;
    endtask

    // Offers the planned beats in bursts of random length. Between bursts the
    // valid line drops for a random gap; a zero gap keeps it high, which gives
    // long stretches of back-to-back beats.
    task automatic send_beats();
        t_turtle_cmd beat;
        int unsigned burst, gap;
        while (beat_plan.size() != 0) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && beat_plan.size() != 0) begin
                beat = beat_plan.pop_front();
                sym_if.valid  <= 1'b1;
                sym_if.action <= beat.action;
                sym_if.symbol <= beat.symbol;
                do @(posedge i_clk); while (!sym_if.ready);
                tracker.take_symbol(beat.action, beat.symbol);
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 || beat_plan.size() == 0) begin
                sym_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Waits until every owed segment has come out, then lets the pipeline
    // empty of beats that owe nothing before a register may change.
    task automatic drain();
        while (tracker.due_segments.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, a short directed walk, then random phases each
    // under its own register setting.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        logic [15:0] start, turn;
        logic [63:0] m0, m1, m2, m3;

        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= tli_pkg::CFG_START_HEADING;
        cfg_data      <= '0;
        sym_if.valid  <= 1'b0;
        sym_if.action <= 1'b0;
        sym_if.symbol <= '0;
        squeeze_request = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk. Codes 0..63 and 192..255 draw, 128..191 do not, and
        // in 64..127 only the even codes draw. Until the first restart the
        // heading starts from the zero left by reset; the restart then loads a
        // quarter turn.
        program_registers(16'h4000, 16'h2000, ALL_ONES, 64'h5555_5555_5555_5555,
                          64'h0, ALL_ONES);
        plan_beat(1'b0, 8'h00);               // first segment from the origin
        plan_beat(1'b0, 8'h00);               // same symbol again stretches it
        plan_beat(1'b0, 8'hFF);               // a different drawing symbol starts anew
        plan_beat(1'b0, tli_pkg::SYM_CLOSE);  // pop on an empty stack
        plan_beat(1'b0, tli_pkg::SYM_PLUS);
        plan_beat(1'b0, tli_pkg::SYM_OPEN);
        plan_beat(1'b0, 8'h41);               // moves without drawing
        plan_beat(1'b0, 8'h40);
        plan_beat(1'b0, 8'h40);
        plan_beat(1'b0, tli_pkg::SYM_CLOSE);  // back to the saved pose
        plan_beat(1'b0, tli_pkg::SYM_MINUS);
        plan_beat(1'b0, tli_pkg::SYM_MINUS);
        plan_beat(1'b0, 8'hFF);
        plan_beat(1'b1, tli_pkg::SYM_OPEN);   // restart; the symbol is ignored
        plan_beat(1'b0, 8'h00);               // matches the cleared last symbol, but
                                              // no segment is open, so it starts one
        plan_beat(1'b0, 8'h00);
        plan_beat(1'b0, 8'h80);
        plan_beat(1'b1, 8'hFF);
        plan_beat(1'b0, tli_pkg::SYM_OPEN);
        plan_beat(1'b0, tli_pkg::SYM_CLOSE);
        plan_beat(1'b0, tli_pkg::SYM_CLOSE);  // the restart emptied the stack
        plan_beat(1'b0, 8'hFF);
        send_beats();

        for (phase = 1; phase <= PHASE_COUNT; phase++) begin
            drain();
            start = 16'($urandom);
            turn  = 16'($urandom);
            m0    = {$urandom, $urandom};
            m1    = {$urandom, $urandom};
            m2    = {$urandom, $urandom};
            m3    = {$urandom, $urandom};
            // Early phases pin the registers to their extremes.
            case (phase)
                1: begin
                    start = 16'h0000;
                    turn  = 16'h2000;
                end
                2: begin
                    start = 16'hFFFF;
                    turn  = 16'hFFFF;
                    {m0, m1, m2, m3} = {4{ALL_ONES}};
                end
                3: begin
                    start = 16'h4000;
                    turn  = 16'h0001;
                    {m0, m1, m2, m3} = {64'h0, ALL_ONES, 64'h0, ALL_ONES};
                end
                4: begin
                    turn = 16'h0000;
                    {m0, m1, m2, m3} = {ALL_ONES, 64'h0, ALL_ONES, 64'h0};
                end
                default: ;
            endcase
            program_registers(start, turn, m0, m1, m2, m3);
            // Every phase opens from a known pose with the new start heading.
            plan_beat(1'b1, 8'($urandom));
            while (beat_plan.size() < PHASE_BEATS) compose_fragment();
            // With every symbol drawing, phase two makes a result on most
            // beats: the right moment to starve the segment side.
            if (phase == 2) begin
                squeeze_request = 1'b1;
            end
            send_beats();
        end

        drain();
        if (tracker.faults == 0 && tracker.due_segments.size() == 0) begin
            $display("turtle_line_interpreter test passed");
        end else begin
            $display("turtle_line_interpreter test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Segment side: ready follows a mode that changes after a random stretch
    // (always ready, coin toss, mostly stalled, mostly ready). Once, on
    // request, ready stays low for a long stretch so that the block backs up
    // and stalls the symbol side while beats are still being offered.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned mode, stretch, k;
        bit          squeeze_done;
        squeeze_done = 1'b0;
        seg_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (squeeze_request && !squeeze_done) begin
                squeeze_done = 1'b1;
                seg_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(8, 80);
            for (k = 0; k < stretch; k++) begin
                case (mode)
                    0: seg_if.ready <= 1'b1;
                    1: seg_if.ready <= 1'($urandom);
                    2: seg_if.ready <= ($urandom_range(0, 3) == 0);
                    default: seg_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Every result beat is checked against the oldest owed segment.
    always @(posedge i_clk) begin : result_monitor
        tli_pkg::t_seg seen;
        if (i_rst_n && seg_if.valid && seg_if.ready) begin
            seen.kind = seg_if.kind;
            seen.xs   = seg_if.x_start;
            seen.ys   = seg_if.y_start;
            seen.xe   = seg_if.x_end;
            seen.ye   = seg_if.y_end;
            tracker.match_segment(seen);
        end
    end

    // Ends the run when neither side has moved a beat for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((sym_if.valid && sym_if.ready) || (seg_if.valid && seg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("turtle_line_interpreter test failed");
        $finish;
    end

endmodule

>>> files.f
sv/tli_pkg.sv
sv/tli_in_if.sv
sv/tli_out_if.sv
sv/tli_ram.sv
sv/tli_stack.sv
sv/tli_qsine.sv
sv/turtle_line_interpreter.sv
tb/testbench.sv
